[rtl/cvl_pkg.sv]
// Shared types and constants for the compacting value list.
`default_nettype none
package cvl_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;
  localparam int OP_W     = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic              cmp_en;
    logic              shift_en;
    logic              append_en;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/cvl_cmd_if.sv]
// Command channel: operation and value with a valid/ready handshake.
`default_nettype none
interface cvl_cmd_if
  import cvl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

[rtl/cvl_rsp_if.sv]
// Result channel: success flag, position and entry count with valid/ready.
`default_nettype none
interface cvl_rsp_if
  import cvl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             success;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output success, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input success, input position, input entry_count,
                  output ready);
endinterface
`default_nettype wire

[rtl/cvl_cell.sv]
// One list position: stored value, registered compare and shift from its neighbor.
`default_nettype none
module cvl_cell
  import cvl_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [VAL_W-1:0] next_entry,
  input  wire logic             hit_in,
  output logic                  hit_out,
  output logic                  match,
  output logic [VAL_W-1:0]      entry
);

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic             match_r, match_nxt;
  logic             in_use;

  assign in_use = ctrl.count > CNT_W'(IDX);

  always_comb begin
    match_nxt = match_r;
    if (ctrl.cmp_en) begin
      match_nxt = in_use && (entry_r == ctrl.value);
    end
  end

  // A delete pulls the right neighbor's value into every cell at or past
  // the first hit; the hit chain tells each cell whether it lies there.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift_en && (hit_in || match_r)) begin
      entry_nxt = next_entry;
    end else if (ctrl.append_en && (ctrl.count == CNT_W'(IDX))) begin
      entry_nxt = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign hit_out = hit_in || match_r;
  assign match   = match_r;
  assign entry   = entry_r;

endmodule
`default_nettype wire

[rtl/compacting_value_list.sv]
// Top level of the compacting value list: sequencer, row of cells, result register.
//
//   channel   dir  handshake        payload
//   in_cmd    in   valid/ready      operation[1:0], value[31:0]
//   out_rsp   out  valid/ready      success, position[3:0], entry_count[4:0]
//   cfg       in   cfg_we (no wait) cfg_wdata[4:0] = max_entries
//
// Each command passes through two steps: a compare, in which all cells compare the value
// in parallel, and an update, in which the first hit is encoded and the row appends (append) or
// shifts (delete). The compare/update pair over the shared row of cells sets the rate.
// A finished result sits in the output register while the next command is
// taken; the update cycle waits only if that register is still full.
// Reset (rst_n low, synchronous) empties the list and sets the limit to 10.
`default_nettype none
module compacting_value_list
  import cvl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  cvl_cmd_if.sink               in_cmd,
  cvl_rsp_if.source             out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  max_entries_r;
  op_t               op_r;
  logic [VAL_W-1:0]  value_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_success_r, out_success_nxt;
  logic [POS_W-1:0]  out_position_r, out_position_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              in_beat;
  logic              in_ready;
  logic              exec_go;
  logic              out_free;
  logic [CNT_W-1:0]  limit;
  logic              app_ok;
  logic              found;
  logic [POS_W-1:0]  hit_pos;

  cell_ctrl_t        ctrl;
  logic [CAPACITY:0] hit;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] first;
  logic [VAL_W-1:0]  entry_arr [CAPACITY];

  assign in_beat  = in_cmd.valid && in_ready;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign limit    = (max_entries_r > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : max_entries_r;
  assign app_ok   = count_r < limit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_cmd.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec_go  = out_free;
      default: begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  assign in_cmd.ready = in_ready;

  always_comb begin
    ctrl.cmp_en    = in_beat;
    ctrl.shift_en  = exec_go && (op_r == OP_DELETE);
    ctrl.append_en = exec_go && (op_r == OP_APPEND) && app_ok;
    ctrl.value     = (state_r == ST_EXEC) ? value_r : in_cmd.value;
    ctrl.count     = count_r;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry_arr[i+1];
    end

    cvl_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .next_entry (nbr),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .match      (match[i]),
      .entry      (entry_arr[i])
    );

    assign first[i] = match[i] && !hit[i];
  end

  assign found = hit[CAPACITY];

  // At most one cell sees the first hit, so its index ORs straight through.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | (first[i] ? POS_W'(i) : POS_W'(0));
    end
  end

  always_comb begin
    count_nxt        = count_r;
    out_success_nxt  = out_success_r;
    out_position_nxt = out_position_r;
    out_count_nxt    = out_count_r;
    out_valid_nxt    = out_rsp.ready ? 1'b0 : out_valid_r;
    if (exec_go) begin
      out_valid_nxt    = 1'b1;
      out_success_nxt  = 1'b0;
      out_position_nxt = '0;
      case (op_r)
        OP_APPEND: begin
          if (app_ok) begin
            out_success_nxt  = 1'b1;
            out_position_nxt = count_r[POS_W-1:0];
            count_nxt        = count_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (found) begin
            out_success_nxt  = 1'b1;
            out_position_nxt = hit_pos;
            count_nxt        = count_r - CNT_W'(1);
          end
        end
        OP_SEARCH: begin
          if (found) begin
            out_success_nxt  = 1'b1;
            out_position_nxt = hit_pos;
          end
        end
        default: out_success_nxt = 1'b0;
      endcase
      out_count_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      max_entries_r <= LIMIT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r    <= op_t'(in_cmd.operation);
      value_r <= in_cmd.value;
    end
    out_success_r  <= out_success_nxt;
    out_position_r <= out_position_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.success     = out_success_r;
  assign out_rsp.position    = out_position_r;
  assign out_rsp.entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // The match flags hold a fresh compare only once a command has been taken.
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> ($onehot0(first) && (found == (first != '0))))
    else $error("first-hit vector not one-hot");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.append_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not grow the list");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.shift_en && found) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r && (state_r == ST_IDLE))
    else $error("update cycle did not produce a result");

endmodule
`default_nettype wire
